// ===== rtl/ofc_pkg.sv =====
package ofc_pkg;

    // Sizes of the fields and of the cascade
    localparam int MAX_STAGES     = 4;
    localparam int SAMPLE_BITS    = 24;
    localparam int GAIN_BITS      = 16;
    localparam int COUNT_BITS     = 3;
    localparam int CFG_IDX_BITS   = 2;
    localparam int CFG_DATA_BITS  = 16;

    // Internal widths, derived from the sample width (the product also from the gain width)
    localparam int INTEG_BITS     = SAMPLE_BITS + 2;
    localparam int DIFF_BITS      = INTEG_BITS + 1;
    localparam int PROD_BITS      = DIFF_BITS + GAIN_BITS;
    localparam int V_BITS         = DIFF_BITS;
    localparam int Y_BITS         = INTEG_BITS + 2;
    localparam int WIDE_BITS      = INTEG_BITS + 3;

    // Digit-serial multiplier: one gain digit a cycle
    localparam int DIGIT_BITS     = 4;
    localparam int DIGITS         = GAIN_BITS / DIGIT_BITS;
    localparam int DIGIT_IDX_BITS = $clog2(DIGITS);

    localparam int STAGE_IDX_BITS = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;

    // Register reset values
    localparam logic [GAIN_BITS-1:0]  GAIN_RESET  = GAIN_BITS'(17763);
    localparam logic                  MODE_RESET  = 1'b0;
    localparam logic [COUNT_BITS-1:0] COUNT_RESET = COUNT_BITS'(1);

    // Half an LSB of v, preloaded into the product accumulator
    localparam logic signed [PROD_BITS-1:0] ROUND_CONST =
        PROD_BITS'(64'sd1 <<< (GAIN_BITS - 1));

    // Saturation limits at the widest internal sum
    localparam logic signed [WIDE_BITS-1:0] INTEG_HI =
        WIDE_BITS'((64'sd1 <<< (INTEG_BITS - 1)) - 64'sd1);
    localparam logic signed [WIDE_BITS-1:0] INTEG_LO = -INTEG_HI - WIDE_BITS'(1);
    localparam logic signed [WIDE_BITS-1:0] SAMPLE_HI =
        WIDE_BITS'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam logic signed [WIDE_BITS-1:0] SAMPLE_LO = -SAMPLE_HI - WIDE_BITS'(1);

    typedef logic [STAGE_IDX_BITS-1:0] t_stage_idx;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_GAIN  = 2'd0,
        CFG_MODE  = 2'd1,
        CFG_COUNT = 2'd2
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_MUL,
        ST_ROUND,
        ST_UPDATE,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic load;
        logic step;
    } t_mul_ctrl;

    typedef struct packed {
        logic round;
        logic highpass;
    } t_post_ctrl;

    function automatic logic signed [INTEG_BITS-1:0] sat_integ(
        input logic signed [WIDE_BITS-1:0] a
    );
        if (a > INTEG_HI) return INTEG_BITS'(INTEG_HI);
        if (a < INTEG_LO) return INTEG_BITS'(INTEG_LO);
        return INTEG_BITS'(a);
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(
        input logic signed [WIDE_BITS-1:0] a
    );
        if (a > SAMPLE_HI) return SAMPLE_BITS'(SAMPLE_HI);
        if (a < SAMPLE_LO) return SAMPLE_BITS'(SAMPLE_LO);
        return SAMPLE_BITS'(a);
    endfunction

    // Index of the last active stage; zero acts as one, excess as the maximum
    function automatic t_stage_idx last_stage(input logic [COUNT_BITS-1:0] count);
        if (count == '0) return '0;
        if (int'(count) > MAX_STAGES) return STAGE_IDX_BITS'(MAX_STAGES - 1);
        return STAGE_IDX_BITS'(int'(count) - 1);
    endfunction

endpackage

// ===== rtl/ofc_in_if.sv =====
interface ofc_in_if import ofc_pkg::*; ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink   (input valid, input sample_in, output ready);
endinterface

// ===== rtl/ofc_out_if.sv =====
interface ofc_out_if import ofc_pkg::*; ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_out;

    modport source (output valid, output sample_out, input ready);
    modport sink   (input valid, input sample_out, output ready);
endinterface

// ===== rtl/ofc_serial_mul.sv =====
module ofc_serial_mul import ofc_pkg::*; (
    input  logic                          i_clk,
    input  t_mul_ctrl                     i_ctrl,
    input  logic signed [DIFF_BITS-1:0]   i_mcand,
    input  logic        [GAIN_BITS-1:0]   i_gain,
    output logic signed [PROD_BITS-1:0]   o_product
);

    logic signed [PROD_BITS-1:0]         r_mcand, n_mcand;
    logic        [GAIN_BITS-1:0]         r_mplier, n_mplier;
    logic signed [PROD_BITS-1:0]         r_acc, n_acc;
    logic        [DIGIT_BITS-1:0]        w_digit;
    logic signed [PROD_BITS+DIGIT_BITS:0] w_part;

    // Partial product of the multiplicand and the lowest gain digit
    assign w_digit = r_mplier[DIGIT_BITS-1:0];
    assign w_part  = r_mcand * $signed({1'b0, w_digit});

    // Load operands and preload the rounding constant, or accumulate one digit and shift both operands on
    always_comb begin
        n_mcand  = r_mcand;
        n_mplier = r_mplier;
        n_acc    = r_acc;
        if (i_ctrl.load) begin
            n_mcand  = PROD_BITS'(i_mcand);
            n_mplier = i_gain;
            n_acc    = ROUND_CONST;
        end else if (i_ctrl.step) begin
            n_acc    = r_acc + w_part[PROD_BITS-1:0];
            n_mcand  = r_mcand <<< DIGIT_BITS;
            n_mplier = r_mplier >> DIGIT_BITS;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mcand  <= n_mcand;
        r_mplier <= n_mplier;
        r_acc    <= n_acc;
    end

    assign o_product = r_acc;

endmodule

// ===== rtl/ofc_stage_post.sv =====
module ofc_stage_post import ofc_pkg::*; (
    input  logic                          i_clk,
    input  t_post_ctrl                    i_ctrl,
    input  logic signed [PROD_BITS-1:0]   i_product,
    input  logic signed [INTEG_BITS-1:0]  i_integ,
    input  logic signed [SAMPLE_BITS-1:0] i_x,
    output logic signed [INTEG_BITS-1:0]  o_integ_next,
    output logic signed [SAMPLE_BITS-1:0] o_stage_out
);

    logic signed [V_BITS-1:0]    w_v;
    logic signed [Y_BITS-1:0]    w_y;
    logic signed [V_BITS-1:0]    r_v;
    logic signed [Y_BITS-1:0]    r_y;
    logic                        r_hp;
    logic signed [WIDE_BITS-1:0] w_sum;
    logic signed [WIDE_BITS-1:0] w_hp_out;
    logic signed [WIDE_BITS-1:0] w_pick;

    // Drop the fraction of the rounded product, then add the state
    assign w_v = i_product[PROD_BITS-1:GAIN_BITS];
    assign w_y = Y_BITS'(w_v) + Y_BITS'(i_integ);

    always_ff @(posedge i_clk) begin
        if (i_ctrl.round) begin
            r_v  <= w_v;
            r_y  <= w_y;
            r_hp <= i_ctrl.highpass;
        end
    end

    // New state and stage output, both saturated
    assign w_sum    = WIDE_BITS'(r_v) + WIDE_BITS'(r_y);
    assign w_hp_out = WIDE_BITS'(i_x) - WIDE_BITS'(r_y);
    assign w_pick   = r_hp ? w_hp_out : WIDE_BITS'(r_y);

    assign o_integ_next = sat_integ(w_sum);
    assign o_stage_out  = sat_sample(w_pick);

endmodule

// ===== rtl/one_pole_tpt_filter_cascade.sv =====
// Each of the N active stages runs load, the 4-bit digit-serial multiply, round and update
// in turn; a new word is accepted only in the idle state, once the last stage has updated
// and the emit state has handed the result to the output register.
// Reset (i_rst_n low at a clock edge) clears the sequencer, the output register,
// all stage integrators, and returns the registers to their reset values.
module one_pole_tpt_filter_cascade import ofc_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    ofc_in_if.sink                   i_in,
    ofc_out_if.source                o_out,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data
);

    t_state                        r_state, n_state;
    logic [GAIN_BITS-1:0]          r_gain;
    logic                          r_mode;
    logic [COUNT_BITS-1:0]         r_count;
    t_stage_idx                    r_stage;
    t_stage_idx                    r_last;
    logic [DIGIT_IDX_BITS-1:0]     r_digit;
    logic signed [SAMPLE_BITS-1:0] r_x;
    logic signed [INTEG_BITS-1:0]  r_integ [MAX_STAGES];
    logic                          r_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_out_data;

    logic                          w_in_ready;
    logic                          w_update;
    logic                          w_emit;
    logic                          w_slot_free;
    logic                          w_last_digit;
    t_mul_ctrl                     w_mul_ctrl;
    t_post_ctrl                    w_post_ctrl;
    logic signed [DIFF_BITS-1:0]   w_diff;
    logic signed [PROD_BITS-1:0]   w_product;
    logic signed [INTEG_BITS-1:0]  w_integ_next;
    logic signed [SAMPLE_BITS-1:0] w_stage_out;

    assign w_slot_free  = !r_out_valid || o_out.ready;
    assign w_last_digit = (r_digit == DIGIT_IDX_BITS'(DIGITS - 1));
    assign w_diff       = DIFF_BITS'(r_x) - DIFF_BITS'(r_integ[r_stage]);

    // Next state of the sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (i_in.valid) n_state = ST_LOAD;
            ST_LOAD:   n_state = ST_MUL;
            ST_MUL:    if (w_last_digit) n_state = ST_ROUND;
            ST_ROUND:  n_state = ST_UPDATE;
            ST_UPDATE: n_state = (r_stage == r_last) ? ST_EMIT : ST_LOAD;
            ST_EMIT:   if (w_slot_free) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        w_in_ready           = 1'b0;
        w_mul_ctrl           = '0;
        w_post_ctrl.round    = 1'b0;
        w_post_ctrl.highpass = r_mode;
        w_update             = 1'b0;
        w_emit               = 1'b0;
        unique case (r_state)
            ST_IDLE:   w_in_ready = 1'b1;
            ST_LOAD:   w_mul_ctrl.load = 1'b1;
            ST_MUL:    w_mul_ctrl.step = 1'b1;
            ST_ROUND:  w_post_ctrl.round = 1'b1;
            ST_UPDATE: w_update = 1'b1;
            ST_EMIT:   w_emit = w_slot_free;
            default:   w_in_ready = 1'b0;
        endcase
    end

    ofc_serial_mul u_mul (
        .i_clk     (i_clk),
        .i_ctrl    (w_mul_ctrl),
        .i_mcand   (w_diff),
        .i_gain    (r_gain),
        .o_product (w_product)
    );

    ofc_stage_post u_post (
        .i_clk        (i_clk),
        .i_ctrl       (w_post_ctrl),
        .i_product    (w_product),
        .i_integ      (r_integ[r_stage]),
        .i_x          (r_x),
        .o_integ_next (w_integ_next),
        .o_stage_out  (w_stage_out)
    );

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain  <= GAIN_RESET;
            r_mode  <= MODE_RESET;
            r_count <= COUNT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_GAIN:  r_gain  <= i_cfg_data[GAIN_BITS-1:0];
                CFG_MODE:  r_mode  <= i_cfg_data[0];
                CFG_COUNT: r_count <= i_cfg_data[COUNT_BITS-1:0];
                default:   r_gain  <= r_gain;
            endcase
        end
    end

    // Sequencer state, stage and digit counters, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_stage     <= '0;
            r_last      <= '0;
            r_digit     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_in_ready && i_in.valid) begin
                r_stage <= '0;
                r_last  <= last_stage(r_count);
            end
            if (w_mul_ctrl.load) r_digit <= '0;
            else if (w_mul_ctrl.step) r_digit <= r_digit + DIGIT_IDX_BITS'(1);
            if (w_update && (r_stage != r_last)) r_stage <= r_stage + STAGE_IDX_BITS'(1);
            if (w_emit) r_out_valid <= 1'b1;
            else if (o_out.ready) r_out_valid <= 1'b0;
        end
    end

    // Stage integrators: cleared at reset, written at the end of each stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < MAX_STAGES; k++) r_integ[k] <= '0;
        end else if (w_update) begin
            r_integ[r_stage] <= w_integ_next;
        end
    end

    // Sample word: take the input, then each stage output in turn
    always_ff @(posedge i_clk) begin
        if (w_in_ready && i_in.valid) r_x <= i_in.sample_in;
        else if (w_update) r_x <= w_stage_out;
        if (w_emit) r_out_data <= r_x;
    end

    assign i_in.ready       = w_in_ready;
    assign o_out.valid      = r_out_valid;
    assign o_out.sample_out = r_out_data;

endmodule

// ===== rtl/ofc_checker.sv =====
module ofc_checker import ofc_pkg::*; (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          i_in_ready,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic signed [SAMPLE_BITS-1:0] i_out_sample
);

    // A stalled result word stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result word dropped while stalled");

    // A stalled result word keeps its value
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_sample))
        else $error("result word changed while stalled");

    // Reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // An accepted word keeps the input closed while the load state and the first multiply step run
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready ##1 !i_in_ready)
        else $error("input reopened too early after accept");

endmodule

bind one_pole_tpt_filter_cascade ofc_checker u_ofc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_sample (o_out.sample_out)
);
